/* hdl/spq_pkg.sv */
package spq_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PRIO_W = 16;
   localparam int PAY_W  = 32;
   localparam int STAT_W = 2;
   localparam int FILL_W = 5;

   typedef enum logic {
      FUNC_ENQ = 1'b0,
      FUNC_DEQ = 1'b1
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      func_type                 func;
      logic [PRIO_W-1:0]        prio;
      logic signed [PAY_W-1:0]  payload;
   } req_word_type;

   typedef struct packed {
      status_type               status;
      logic signed [PAY_W-1:0]  out_payload;
      logic [FILL_W-1:0]        fill;
   } rsp_word_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

/* hdl/spq_ctrl.sv */
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::cmd_type cmd
);

   spq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = spq_pkg::ST_IDLE;
            end
         end
         default: state_in = spq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         spq_pkg::ST_EXEC: begin
            cmd.exec = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/spq_dpath.sv */
module spq_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cmd_type      cmd,
   input  spq_pkg::req_word_type req_word,
   output spq_pkg::rsp_word_type rsp_word
);

   spq_pkg::req_word_type      req_ff;
   spq_pkg::rsp_word_type      rsp_ff, rsp_in;
   logic [spq_pkg::PRIO_W-1:0] prio_ff [spq_pkg::DEPTH];
   logic [spq_pkg::PRIO_W-1:0] prio_in [spq_pkg::DEPTH];
   logic [spq_pkg::PAY_W-1:0]  pay_ff  [spq_pkg::DEPTH];
   logic [spq_pkg::PAY_W-1:0]  pay_in  [spq_pkg::DEPTH];
   logic [spq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [spq_pkg::DEPTH-1:0]  le;
   logic                       full;
   logic                       empty;

   assign full  = count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH);
   assign empty = count_ff == '0;

   // The list is sorted, so the cells at or below the new priority form a prefix.
   always_comb begin
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
         le[i] = (spq_pkg::CNT_W'(i) < count_ff) && (prio_ff[i] <= req_ff.prio);
      end
   end

   always_comb begin
      prio_in            = prio_ff;
      pay_in             = pay_ff;
      count_in           = count_ff;
      rsp_in             = rsp_ff;
      rsp_in.status      = spq_pkg::STATUS_OK;
      rsp_in.out_payload = '0;
      if (cmd.exec) begin
         unique case (req_ff.func)
            spq_pkg::FUNC_ENQ: begin
               if (full) begin
                  rsp_in.status = spq_pkg::STATUS_FULL;
               end else begin
                  if (!le[0]) begin
                     prio_in[0] = req_ff.prio;
                     pay_in[0]  = req_ff.payload;
                  end
                  for (int i = 1; i < spq_pkg::DEPTH; i++) begin
                     if (!le[i]) begin
                        if (le[i-1]) begin
                           prio_in[i] = req_ff.prio;
                           pay_in[i]  = req_ff.payload;
                        end else begin
                           prio_in[i] = prio_ff[i-1];
                           pay_in[i]  = pay_ff[i-1];
                        end
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            spq_pkg::FUNC_DEQ: begin
               if (empty) begin
                  rsp_in.status = spq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.out_payload = pay_ff[0];
                  for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
                     prio_in[i] = prio_ff[i+1];
                     pay_in[i]  = pay_ff[i+1];
                  end
                  count_in = count_ff - 1'b1;
               end
            end
            default: rsp_in.status = spq_pkg::STATUS_OK;
         endcase
         rsp_in.fill = spq_pkg::FILL_W'(count_in);
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
      prio_ff <= prio_in;
      pay_ff  <= pay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

/* hdl/sorted_priority_queue.sv */
// A word accepted into the request register gives its result in the output register.
// No new word is taken while one is executing; a stalled result holds the next
// word in the execute step until the output register is free.
// Insert and remove each act on a row of compare-and-shift cells.
// Reset clears the entry count and the handshake state; cell contents are not cleared.
module sorted_priority_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spq_pkg::rsp_word_type rsp_word
);

   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

/* hdl/spq_checker.sv */
module spq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input spq_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input spq_pkg::rsp_word_type rsp_word
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_word))
      else $error("Request word changed while waiting.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("Result word changed while stalled.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == spq_pkg::STATUS_FULL
      |-> rsp_word.fill == spq_pkg::FILL_W'(spq_pkg::DEPTH) && rsp_word.out_payload == '0)
      else $error("Full report with wrong fill or payload.");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == spq_pkg::STATUS_EMPTY
      |-> rsp_word.fill == '0 && rsp_word.out_payload == '0)
      else $error("Empty report with wrong fill or payload.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
